/* src/utf8c_pkg.sv */
// Shared types, constants and the code point check for the UTF-8 name checker.
package utf8c_pkg;

  localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
  localparam logic [7:0]  CONT_MASK    = 8'hC0;
  localparam logic [7:0]  CONT_TAG     = 8'h80;
  localparam logic [20:0] MIN_3BYTE    = 21'h000800;
  localparam logic [20:0] MIN_4BYTE    = 21'h010000;
  localparam logic [20:0] MAX_CP       = 21'h10FFFF;
  localparam logic [20:0] SURR_LO      = 21'h00D800;
  localparam logic [20:0] SURR_HI      = 21'h00DFFF;
  localparam logic [20:0] CTRL_C0_END  = 21'h000020;
  localparam logic [20:0] CTRL_DEL     = 21'h00007F;
  localparam logic [20:0] CTRL_C1_END  = 21'h00009F;

  localparam logic [1:0] SEQ_1BYTE = 2'd0;
  localparam logic [1:0] SEQ_2BYTE = 2'd1;
  localparam logic [1:0] SEQ_3BYTE = 2'd2;
  localparam logic [1:0] SEQ_4BYTE = 2'd3;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]  pend;
    logic [1:0]  seqc;
    logic [20:0] cp;
    logic        failed;
  } dec_state_t;

  function automatic logic cp_bad(input logic [20:0] cp, input logic [1:0] seqc);
    logic bad;
    bad = 1'b0;
    if (seqc == SEQ_3BYTE && cp < MIN_3BYTE) bad = 1'b1;
    if (seqc == SEQ_4BYTE && cp < MIN_4BYTE) bad = 1'b1;
    if (cp > MAX_CP) bad = 1'b1;
    if (cp >= SURR_LO && cp <= SURR_HI) bad = 1'b1;
    if (cp < CTRL_C0_END) bad = 1'b1;
    if (cp >= CTRL_DEL && cp <= CTRL_C1_END) bad = 1'b1;
    return bad;
  endfunction

endpackage

/* src/utf8c_decode.sv */
// Next-state and verdict logic for one name item.
module utf8c_decode #(
  parameter int MAX_NAME_BYTES = 32,
  parameter int CntW = 6
) (
  input  utf8c_pkg::dec_state_t st,
  input  logic [CntW-1:0]       cnt,
  input  logic [7:0]            byte_value,
  input  logic                  has_byte,
  input  logic                  last_byte,
  output utf8c_pkg::dec_state_t st_nxt,
  output logic [CntW-1:0]       cnt_nxt,
  output logic                  name_valid
);

  utf8c_pkg::dec_state_t st_b;
  logic [CntW-1:0]       cnt_b;

  always_comb begin
    st_b  = st;
    cnt_b = cnt;
    if (has_byte) begin
      if (cnt < CntW'(MAX_NAME_BYTES + 1)) cnt_b = cnt + CntW'(1);
      if (st.pend == 2'd0) begin
        if (byte_value[7] == 1'b0) begin
          st_b.cp   = {14'd0, byte_value[6:0]};
          st_b.seqc = utf8c_pkg::SEQ_1BYTE;
          if (utf8c_pkg::cp_bad(st_b.cp, utf8c_pkg::SEQ_1BYTE)) st_b.failed = 1'b1;
        end else if (byte_value >= utf8c_pkg::LEAD2_MIN &&
                     byte_value <= utf8c_pkg::LEAD2_MAX) begin
          st_b.cp   = {16'd0, byte_value[4:0]};
          st_b.seqc = utf8c_pkg::SEQ_2BYTE;
          st_b.pend = 2'd1;
        end else if (byte_value >= utf8c_pkg::LEAD3_MIN &&
                     byte_value <= utf8c_pkg::LEAD3_MAX) begin
          st_b.cp   = {17'd0, byte_value[3:0]};
          st_b.seqc = utf8c_pkg::SEQ_3BYTE;
          st_b.pend = 2'd2;
        end else if (byte_value >= utf8c_pkg::LEAD4_MIN &&
                     byte_value <= utf8c_pkg::LEAD4_MAX) begin
          st_b.cp   = {18'd0, byte_value[2:0]};
          st_b.seqc = utf8c_pkg::SEQ_4BYTE;
          st_b.pend = 2'd3;
        end else begin
          st_b.failed = 1'b1;
        end
      end else if ((byte_value & utf8c_pkg::CONT_MASK) != utf8c_pkg::CONT_TAG) begin
        // A broken sequence fails the name; decoding restarts at the next byte.
        st_b.failed = 1'b1;
        st_b.pend   = 2'd0;
      end else begin
        st_b.cp   = {st.cp[14:0], byte_value[5:0]};
        st_b.pend = st.pend - 2'd1;
        if (st.pend == 2'd1 && utf8c_pkg::cp_bad(st_b.cp, st.seqc)) st_b.failed = 1'b1;
      end
    end

    name_valid = !st_b.failed && st_b.pend == 2'd0 &&
                 cnt_b <= CntW'(MAX_NAME_BYTES);

    if (last_byte) begin
      st_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      st_nxt  = st_b;
      cnt_nxt = cnt_b;
    end
  end

endmodule

/* src/utf8_display_name_checker_core.sv */
// Top level of the UTF-8 display name checker: input register, decoder state, result register.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_byte_value, in_has_byte, | in
//          | in_last_byte                                   |
//  result  | out_valid, out_stall, out_name_valid           | out
//
// An item is decoded while it sits in the input register; one byte per cycle is
// sustained, set by the single decode stage, while no last item waits on a stalled verdict.
// The verdict is loaded into the result register at the edge that retires the last item,
// so out_valid is registered and rises once that item leaves the input register.
// rst_n is synchronous and clears all name state and both valid flags.
// A stalled verdict holds only an item that carries the last mark; others pass.
module utf8_display_name_checker_core #(
  parameter int MAX_NAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_has_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_name_valid
);

  localparam int CntW = $clog2(MAX_NAME_BYTES + 2);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_has_r;
  logic       s1_last_r;

  utf8c_pkg::dec_state_t st_r, st_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  verdict;

  logic out_valid_r;
  logic out_name_valid_r;
  logic out_free;
  logic s1_go;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte_value;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last_byte;
    end
  end

  utf8c_decode #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .CntW          (CntW)
  ) u_decode (
    .st        (st_r),
    .cnt       (cnt_r),
    .byte_value(s1_byte_r),
    .has_byte  (s1_has_r),
    .last_byte (s1_last_r),
    .st_nxt    (st_nxt),
    .cnt_nxt   (cnt_nxt),
    .name_valid(verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (s1_go) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_name_valid_r <= verdict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_name_valid = out_name_valid_r;

  a_clear_after_verdict : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (st_r == '0 && cnt_r == '0))
    else $error("name state not cleared after verdict");

  a_cnt_saturates : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MAX_NAME_BYTES + 1))
    else $error("byte count above saturation value");

  a_verdict_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_last_r))
    else $error("result raised without a last item");

  a_pend_bound : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pend <= st_r.seqc)
    else $error("pending count exceeds sequence length");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked verdict");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the UTF-8 display name checker core.
module tb_top;

  localparam int NAME_LIMIT    = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_value = 8'h00;
  logic       in_has_byte = 1'b0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_name_valid;

  int         cycle_count = 0;
  int         items_sent = 0;
  int         mismatches = 0;
  bit         idle_on = 1'b1;
  bit         verdicts_due[$];
  logic [7:0] name_q[$];

  // Decoder state of the predictor.
  logic [1:0]  dec_pend = 2'd0;
  logic [1:0]  dec_seq = utf8c_pkg::SEQ_1BYTE;
  logic [20:0] dec_cp = 21'd0;
  logic [5:0]  name_len = 6'd0;
  logic        name_bad = 1'b0;
  bit          got_verdict;

  utf8_display_name_checker_core #(
    .MAX_NAME_BYTES(NAME_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_has_byte   (in_has_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_name_valid(out_name_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_on && rst_n && ($urandom_range(99) < 17);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict transfer with no name pending");
      end else begin
        got_verdict = verdicts_due.pop_front();
        if (out_name_valid !== got_verdict)
          report_mismatch($sformatf("name_valid is %b, predicted %b",
                                    out_name_valid, got_verdict));
      end
    end
  end

  function automatic logic code_point_rejected(input logic [20:0] cp, input logic [1:0] seq);
    logic rejected;
    case (seq)
      utf8c_pkg::SEQ_3BYTE: rejected = cp < utf8c_pkg::MIN_3BYTE;
      utf8c_pkg::SEQ_4BYTE: rejected = cp < utf8c_pkg::MIN_4BYTE;
      default:              rejected = 1'b0;
    endcase
    // Range limit, surrogates, then C0, DEL and C1 controls.
    if (cp > utf8c_pkg::MAX_CP ||
        (cp >= utf8c_pkg::SURR_LO && cp <= utf8c_pkg::SURR_HI)) rejected = 1'b1;
    if (cp < utf8c_pkg::CTRL_C0_END ||
        (cp >= utf8c_pkg::CTRL_DEL && cp <= utf8c_pkg::CTRL_C1_END)) rejected = 1'b1;
    return rejected;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    if (name_len <= NAME_LIMIT) name_len = name_len + 6'd1;
    if (dec_pend == 2'd0) begin
      if (b < utf8c_pkg::CONT_TAG) begin
        dec_cp = {13'd0, b};
        dec_seq = utf8c_pkg::SEQ_1BYTE;
        if (code_point_rejected(dec_cp, dec_seq)) name_bad = 1'b1;
      end else if (b >= utf8c_pkg::LEAD2_MIN && b <= utf8c_pkg::LEAD2_MAX) begin
        dec_cp = {16'd0, b[4:0]};
        dec_seq = utf8c_pkg::SEQ_2BYTE;
        dec_pend = 2'd1;
      end else if (b >= utf8c_pkg::LEAD3_MIN && b <= utf8c_pkg::LEAD3_MAX) begin
        dec_cp = {17'd0, b[3:0]};
        dec_seq = utf8c_pkg::SEQ_3BYTE;
        dec_pend = 2'd2;
      end else if (b >= utf8c_pkg::LEAD4_MIN && b <= utf8c_pkg::LEAD4_MAX) begin
        dec_cp = {18'd0, b[2:0]};
        dec_seq = utf8c_pkg::SEQ_4BYTE;
        dec_pend = 2'd3;
      end else begin
        name_bad = 1'b1;
      end
    end else if ((b & utf8c_pkg::CONT_MASK) != utf8c_pkg::CONT_TAG) begin
      // A broken sequence is abandoned; this byte is not decoded as a new lead.
      name_bad = 1'b1;
      dec_pend = 2'd0;
    end else begin
      dec_cp = {dec_cp[14:0], b[5:0]};
      dec_pend = dec_pend - 2'd1;
      if (dec_pend == 2'd0 && code_point_rejected(dec_cp, dec_seq)) name_bad = 1'b1;
    end
  endtask

  task automatic predict_verdict(input logic [7:0] b, input logic has, input logic last);
    if (has) absorb_byte(b);
    if (last) begin
      verdicts_due.push_back(!name_bad && dec_pend == 2'd0 && name_len <= NAME_LIMIT);
      dec_pend = 2'd0;
      dec_seq = utf8c_pkg::SEQ_1BYTE;
      dec_cp = 21'd0;
      name_len = 6'd0;
      name_bad = 1'b0;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_has_byte <= has;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_verdict(b, has, last);
    items_sent++;
  endtask

  // Sends name_q as one name; optionally sprinkles ignored items and closes
  // the name with an item that carries no byte.
  task automatic send_name(input bit pad_ignored, input bit close_empty);
    int i;
    if (name_q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    for (i = 0; i < name_q.size(); i++) begin
      if (pad_ignored && $urandom_range(99) < 6)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(name_q[i], 1'b1, !close_empty && i == name_q.size() - 1);
    end
    if (close_empty) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_bytes(input int n, input logic [31:0] packed_bytes);
    int i;
    name_q.delete();
    for (i = 0; i < n; i++) name_q.push_back(packed_bytes[8*(n-1-i) +: 8]);
    send_name(1'b0, 1'b0);
  endtask

  // Encodes a code point in the given number of bytes, overlong if asked.
  task automatic append_cp(input logic [20:0] cp, input int len);
    case (len)
      1: name_q.push_back({1'b0, cp[6:0]});
      2: begin
        name_q.push_back({3'b110, cp[10:6]});
        name_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        name_q.push_back({4'b1110, cp[15:12]});
        name_q.push_back({2'b10, cp[11:6]});
        name_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        name_q.push_back({5'b11110, cp[20:18]});
        name_q.push_back({2'b10, cp[17:12]});
        name_q.push_back({2'b10, cp[11:6]});
        name_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic append_good_cp();
    case ($urandom_range(3))
      0: append_cp(21'($urandom_range(21'h20, 21'h7E)), 1);
      1: append_cp(21'($urandom_range(21'hA0, 21'h7FF)), 2);
      2: append_cp(21'($urandom_range(21'hE000, 21'hFFFF)), 3);
      default: append_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
    endcase
  endtask

  task automatic append_random_cp();
    int pick;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 35)      append_cp(21'($urandom_range(21'h20, 21'h7E)), 1);
    else if (pick < 43) append_cp(21'($urandom_range(21'h0, 21'h7F)), 1);
    else if (pick < 58) append_cp(21'($urandom_range(21'h80, 21'h7FF)), 2);
    else if (pick < 70) append_cp(21'($urandom_range(21'h800, 21'hFFFF)), 3);
    else if (pick < 76) append_cp(21'($urandom_range(21'hD7F0, 21'hE00F)), 3);
    else if (pick < 88) append_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
    else if (pick < 92) append_cp(21'($urandom_range(21'h10FFF0, 21'h11000F)), 4);
    else if (pick < 95) append_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
    else begin
      cp = 21'($urandom_range(21'h0, 21'hFFFF));
      if (cp < 21'h80)       append_cp(cp, $urandom_range(2, 4));
      else if (cp < 21'h800) append_cp(cp, $urandom_range(3, 4));
      else                   append_cp(cp, 4);
    end
  endtask

  task automatic send_random_name(input int max_cps);
    int shape, count, k, pos;
    name_q.delete();
    shape = $urandom_range(99);
    count = $urandom_range(0, max_cps);
    if (shape < 12) begin
      for (k = 0; k <= count; k++) name_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (k = 0; k < count; k++) append_random_cp();
      if (shape < 24 && name_q.size() > 0) begin
        pos = $urandom_range(0, name_q.size() - 1);
        case ($urandom_range(2))
          0: void'(name_q.pop_back());
          1: name_q[pos] = 8'($urandom_range(0, 255));
          default: name_q.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_name(1'b1, $urandom_range(99) < 8);
  endtask

  task automatic wait_for_verdicts();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_and_ascii();
    send_item(8'hA5, 1'b0, 1'b1);
    send_bytes(2, 32'h207E);
    send_bytes(1, 32'h1F);
    send_bytes(1, 32'h00);
    send_bytes(1, 32'h7F);
  endtask

  task automatic test_lead_bytes();
    send_bytes(1, 32'h80);
    send_bytes(2, 32'hC1BF);
    send_bytes(1, 32'hF5);
    send_bytes(1, 32'hFF);
    send_bytes(2, 32'hC2A0);
    send_bytes(2, 32'hC29F);
  endtask

  task automatic test_sequence_limits();
    send_bytes(3, 32'hE09FBF);
    send_bytes(3, 32'hEDA080);
    send_bytes(4, 32'hF08FBFBF);
    send_bytes(4, 32'hF4908080);
    send_bytes(4, 32'hF48FBFBF);
  endtask

  task automatic test_broken_sequences();
    send_bytes(2, 32'hC341);
    send_bytes(4, 32'hE041C3A9);
    // Unfinished sequence closed by an item without a byte.
    name_q.delete();
    name_q.push_back(8'hE2);
    name_q.push_back(8'h82);
    send_name(1'b0, 1'b1);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h42, 1'b1, 1'b1);
  endtask

  task automatic test_name_length();
    int target, k;
    for (k = 0; k < 5; k++) begin
      case (k)
        0: target = NAME_LIMIT - 1;
        1: target = NAME_LIMIT;
        2: target = NAME_LIMIT + 1;
        3: target = $urandom_range(NAME_LIMIT + 2, 2 * NAME_LIMIT);
        default: target = 2 * NAME_LIMIT + 6;
      endcase
      name_q.delete();
      while (name_q.size() + 4 <= target && $urandom_range(3) != 0) append_good_cp();
      while (name_q.size() < target) name_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      send_name(1'b1, k == 4);
    end
  endtask

  task automatic test_random_names(input int item_goal);
    int start;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      if ($urandom_range(99) < 4) send_random_name(14);
      else send_random_name(6);
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_names(200);
    wait_for_verdicts();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_ascii();
    test_lead_bytes();
    test_sequence_limits();
    test_broken_sequences();
    wait_for_verdicts();
    test_name_length();
    test_random_names(300);
    wait_for_verdicts();
    test_back_to_back();
    test_random_names(200);
    wait_for_verdicts();
    if (verdicts_due.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
